/* rtl/crpf_pkg.sv */
// ----------------------------------------------------------------------------
// crpf_pkg
// Types and constants shared by the control register pin filter.
// ----------------------------------------------------------------------------
package crpf_pkg;

  localparam int unsigned XLEN      = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // access types
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLTS  = 2'd2;
  localparam logic [1:0] MODE_LMSW  = 2'd3;

  // control register numbers
  localparam logic [3:0] CR_0 = 4'd0;
  localparam logic [3:0] CR_3 = 4'd3;
  localparam logic [3:0] CR_4 = 4'd4;

  // stack pointer general register
  localparam logic [3:0] GPR_SP = 4'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CR0_PIN_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CR0_PIN_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CR4_PIN_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CR4_PIN_VALUE = 2'd3;

  localparam logic [XLEN-1:0] CR0_PE_BIT = 64'h1;
  localparam logic [XLEN-1:0] CR0_TS_BIT = 64'h8;
  localparam logic [XLEN-1:0] LMSW_BITS  = 64'hF;

  typedef struct packed {
    logic [3:0]      cr_number;
    logic [1:0]      mode;
    logic [3:0]      gpr_index;
    logic [15:0]     lmsw_source;
    logic [XLEN-1:0] gpr_value;
  } crpf_in_t;

  typedef struct packed {
    logic            handled;
    logic            write_back;
    logic [XLEN-1:0] read_data;
    logic            refused;
    logic [XLEN-1:0] refused_total;
    logic [XLEN-1:0] cr3_switch_total;
  } crpf_out_t;

  typedef struct packed {
    logic [XLEN-1:0] cr0_pin_mask;
    logic [XLEN-1:0] cr0_pin_value;
    logic [XLEN-1:0] cr4_pin_mask;
    logic [XLEN-1:0] cr4_pin_value;
  } crpf_cfg_t;

endpackage

/* rtl/crpf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// crpf_cfg_regs
// Pin mask and pin value registers, written through the configuration port.
// ----------------------------------------------------------------------------
module crpf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [crpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crpf_pkg::XLEN-1:0]       cfg_wdata,
  output crpf_pkg::crpf_cfg_t             cfg_o
);
  import crpf_pkg::*;

  crpf_cfg_t cfg_r;
  crpf_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CR0_PIN_MASK:  cfg_nxt.cr0_pin_mask  = cfg_wdata;
        CFG_CR0_PIN_VALUE: cfg_nxt.cr0_pin_value = cfg_wdata;
        CFG_CR4_PIN_MASK:  cfg_nxt.cr4_pin_mask  = cfg_wdata;
        CFG_CR4_PIN_VALUE: cfg_nxt.cr4_pin_value = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* rtl/crpf_core.sv */
// ----------------------------------------------------------------------------
// crpf_core
// Guest control register state, read shadows and counters; services one
// request per commit and produces its result combinationally.
// ----------------------------------------------------------------------------
module crpf_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  commit,
  input  crpf_pkg::crpf_in_t    req_i,
  input  crpf_pkg::crpf_cfg_t   cfg_i,
  output crpf_pkg::crpf_out_t   res_o
);
  import crpf_pkg::*;

  logic [XLEN-1:0] guest_cr0_r, guest_cr3_r, guest_cr4_r;
  logic [XLEN-1:0] cr0_shadow_r, cr4_shadow_r;
  logic [XLEN-1:0] refused_cnt_r, cr3_sw_cnt_r;

  logic            is_cr0, is_cr3, is_cr4, sp_named;
  logic            cr3_wr, cr3_rd, cr0_op, cr4_op;
  logic [XLEN-1:0] cr0_req, cr0_merged, cr4_merged;
  logic            cr0_bad, cr4_bad, refused;
  logic [XLEN-1:0] refused_cnt_nxt, cr3_sw_cnt_nxt;

  assign is_cr0   = (req_i.cr_number == CR_0);
  assign is_cr3   = (req_i.cr_number == CR_3);
  assign is_cr4   = (req_i.cr_number == CR_4);
  assign sp_named = (req_i.gpr_index == GPR_SP);

  assign cr3_wr = is_cr3 && !sp_named && (req_i.mode == MODE_WRITE);
  assign cr3_rd = is_cr3 && !sp_named && (req_i.mode == MODE_READ);
  // clts and lmsw ignore the general register
  assign cr0_op = is_cr0 && ((req_i.mode == MODE_CLTS) || (req_i.mode == MODE_LMSW) ||
                             ((req_i.mode == MODE_WRITE) && !sp_named));
  assign cr4_op = is_cr4 && (req_i.mode == MODE_WRITE) && !sp_named;

  always_comb begin
    case (req_i.mode)
      MODE_CLTS: cr0_req = guest_cr0_r & ~CR0_TS_BIT;
      // lmsw can set pe but never clear it
      MODE_LMSW: cr0_req = (guest_cr0_r & ~LMSW_BITS)
                         | ({{(XLEN-16){1'b0}}, req_i.lmsw_source} & LMSW_BITS)
                         | (guest_cr0_r & CR0_PE_BIT);
      default:   cr0_req = req_i.gpr_value;
    endcase
  end

  assign cr0_bad    = (cr0_req & cfg_i.cr0_pin_mask) !=
                      (cfg_i.cr0_pin_value & cfg_i.cr0_pin_mask);
  assign cr4_bad    = (req_i.gpr_value & cfg_i.cr4_pin_mask) !=
                      (cfg_i.cr4_pin_value & cfg_i.cr4_pin_mask);
  assign cr0_merged = (cr0_req & ~cfg_i.cr0_pin_mask) |
                      (cfg_i.cr0_pin_value & cfg_i.cr0_pin_mask);
  assign cr4_merged = (req_i.gpr_value & ~cfg_i.cr4_pin_mask) |
                      (cfg_i.cr4_pin_value & cfg_i.cr4_pin_mask);

  assign refused         = (cr0_op && cr0_bad) || (cr4_op && cr4_bad);
  assign refused_cnt_nxt = refused_cnt_r + {{(XLEN-1){1'b0}}, refused};
  assign cr3_sw_cnt_nxt  = cr3_sw_cnt_r + {{(XLEN-1){1'b0}}, cr3_wr};

  always_comb begin
    res_o.handled          = cr3_wr || cr3_rd || cr0_op || cr4_op;
    res_o.write_back       = cr3_rd;
    res_o.read_data        = cr3_rd ? guest_cr3_r : '0;
    res_o.refused          = refused;
    res_o.refused_total    = refused_cnt_nxt;
    res_o.cr3_switch_total = cr3_sw_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guest_cr0_r   <= '0;
      guest_cr3_r   <= '0;
      guest_cr4_r   <= '0;
      cr0_shadow_r  <= '0;
      cr4_shadow_r  <= '0;
      refused_cnt_r <= '0;
      cr3_sw_cnt_r  <= '0;
    end else if (commit) begin
      refused_cnt_r <= refused_cnt_nxt;
      cr3_sw_cnt_r  <= cr3_sw_cnt_nxt;
      if (cr3_wr) begin
        guest_cr3_r <= req_i.gpr_value;
      end
      if (cr0_op) begin
        guest_cr0_r  <= cr0_merged;
        cr0_shadow_r <= cr0_req;
      end
      if (cr4_op) begin
        guest_cr4_r  <= cr4_merged;
        cr4_shadow_r <= req_i.gpr_value;
      end
    end
  end

  // shadows hold what the guest asked for; kept for read-shadow export
  logic shadow_unused;
  assign shadow_unused = ^{cr0_shadow_r, cr4_shadow_r, guest_cr4_r};

endmodule

/* rtl/control_register_pin_filter.sv */
// ----------------------------------------------------------------------------
// control_register_pin_filter
// Services intercepted control register accesses: cr3 replay and read,
// pinned cr0/cr4 writes, clts and lmsw, with refusal and switch counters.
//
//   channel  direction  handshake        payload
//   in_      input      valid / ready    crpf_in_t
//   out_     output     valid / ready    crpf_out_t
//   cfg_     input      write enable     index, 64-bit data
//
// One request per cycle when out_ready stays high; the result passes through
// the input register, then the result register, before it is valid.
// State is read and updated by one pass of logic between the two registers.
// A stalled result holds in the result register, the next request in the input
// register; synchronous active-low reset clears all state but req_r and res_r.
// ----------------------------------------------------------------------------
module control_register_pin_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  crpf_pkg::crpf_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output crpf_pkg::crpf_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [crpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crpf_pkg::XLEN-1:0]       cfg_wdata
);
  import crpf_pkg::*;

  crpf_in_t  req_r;
  logic      req_vld_r;
  crpf_out_t res_r;
  logic      res_vld_r;
  crpf_out_t res;
  crpf_cfg_t cfg;
  logic      advance;

  assign advance   = req_vld_r && (!res_vld_r || out_ready);
  assign in_ready  = !req_vld_r || advance;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  crpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  crpf_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (advance),
    .req_i  (req_r),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (advance) begin
      res_r <= res;
    end
  end

endmodule
